/* rtl/core/scd_pkg.sv */
// Shared constants, types and key tables for the set-1 scancode decoder.
`default_nettype none

package scd_pkg;

    localparam logic [7:0] PREFIX_BYTE = 8'hE0;
    localparam int unsigned CODE_W     = 7;
    localparam int unsigned CHAR_W     = 7;

    localparam logic [CODE_W-1:0] KEY_LSHIFT = 7'd42;
    localparam logic [CODE_W-1:0] KEY_RSHIFT = 7'd54;
    localparam logic [CODE_W-1:0] KEY_CTRL   = 7'd29;
    localparam logic [CODE_W-1:0] KEY_ALT    = 7'd56;
    localparam logic [CODE_W-1:0] KEY_CAPS   = 7'd58;

    // extended keys with a character
    localparam logic [CODE_W-1:0] EXT_KP_ENTER = 7'd28;
    localparam logic [CODE_W-1:0] EXT_KP_SLASH = 7'd53;
    localparam logic [CODE_W-1:0] EXT_HOME     = 7'd71;
    localparam logic [CODE_W-1:0] EXT_DELETE   = 7'd83;

    localparam logic [CHAR_W-1:0] CHAR_NONE = 7'h00;
    localparam logic [CHAR_W-1:0] CHAR_INTR = 7'h03;
    localparam logic [CHAR_W-1:0] CHAR_LF   = 7'h0A;
    localparam logic [CHAR_W-1:0] CHAR_ESC  = 7'h1B;
    localparam logic [CHAR_W-1:0] CHAR_DEL  = 7'h7F;

    typedef struct packed {
        logic shift;
        logic ctrl;
        logic alt;
        logic caps;
    } mod_flags_t;

    // JIS layout, unshifted
    function automatic logic [CHAR_W-1:0] plain_char(input logic [CODE_W-1:0] code);
        logic [CHAR_W-1:0] c;
        unique case (code)
            7'd1:    c = 7'h1B;
            7'd2:    c = 7'h31;
            7'd3:    c = 7'h32;
            7'd4:    c = 7'h33;
            7'd5:    c = 7'h34;
            7'd6:    c = 7'h35;
            7'd7:    c = 7'h36;
            7'd8:    c = 7'h37;
            7'd9:    c = 7'h38;
            7'd10:   c = 7'h39;
            7'd11:   c = 7'h30;
            7'd12:   c = 7'h2D; // -
            7'd13:   c = 7'h5E; // ^
            7'd14:   c = 7'h08;
            7'd15:   c = 7'h09;
            7'd16:   c = 7'h71;
            7'd17:   c = 7'h77;
            7'd18:   c = 7'h65;
            7'd19:   c = 7'h72;
            7'd20:   c = 7'h74;
            7'd21:   c = 7'h79;
            7'd22:   c = 7'h75;
            7'd23:   c = 7'h69;
            7'd24:   c = 7'h6F;
            7'd25:   c = 7'h70;
            7'd26:   c = 7'h40; // @
            7'd27:   c = 7'h5B; // [
            7'd28:   c = 7'h0A;
            7'd30:   c = 7'h61;
            7'd31:   c = 7'h73;
            7'd32:   c = 7'h64;
            7'd33:   c = 7'h66;
            7'd34:   c = 7'h67;
            7'd35:   c = 7'h68;
            7'd36:   c = 7'h6A;
            7'd37:   c = 7'h6B;
            7'd38:   c = 7'h6C;
            7'd39:   c = 7'h3B; // ;
            7'd40:   c = 7'h3A; // :
            7'd43:   c = 7'h5D; // ]
            7'd44:   c = 7'h7A;
            7'd45:   c = 7'h78;
            7'd46:   c = 7'h63;
            7'd47:   c = 7'h76;
            7'd48:   c = 7'h62;
            7'd49:   c = 7'h6E;
            7'd50:   c = 7'h6D;
            7'd51:   c = 7'h2C; // ,
            7'd52:   c = 7'h2E; // .
            7'd53:   c = 7'h2F; // /
            7'd55:   c = 7'h2A; // *
            7'd57:   c = 7'h20;
            7'h73:   c = 7'h5C; // ro key
            7'h7D:   c = 7'h5C; // yen key
            default: c = CHAR_NONE;
        endcase
        return c;
    endfunction

    // JIS layout, shifted
    function automatic logic [CHAR_W-1:0] shift_char(input logic [CODE_W-1:0] code);
        logic [CHAR_W-1:0] c;
        unique case (code)
            7'd1:    c = 7'h1B;
            7'd2:    c = 7'h21;
            7'd3:    c = 7'h22;
            7'd4:    c = 7'h23;
            7'd5:    c = 7'h24;
            7'd6:    c = 7'h25;
            7'd7:    c = 7'h26;
            7'd8:    c = 7'h27;
            7'd9:    c = 7'h28;
            7'd10:   c = 7'h29;
            7'd11:   c = 7'h7E;
            7'd12:   c = 7'h3D;
            7'd13:   c = 7'h7E;
            7'd14:   c = 7'h08;
            7'd15:   c = 7'h09;
            7'd16:   c = 7'h51;
            7'd17:   c = 7'h57;
            7'd18:   c = 7'h45;
            7'd19:   c = 7'h52;
            7'd20:   c = 7'h54;
            7'd21:   c = 7'h59;
            7'd22:   c = 7'h55;
            7'd23:   c = 7'h49;
            7'd24:   c = 7'h4F;
            7'd25:   c = 7'h50;
            7'd26:   c = 7'h60;
            7'd27:   c = 7'h7B;
            7'd28:   c = 7'h0A;
            7'd30:   c = 7'h41;
            7'd31:   c = 7'h53;
            7'd32:   c = 7'h44;
            7'd33:   c = 7'h46;
            7'd34:   c = 7'h47;
            7'd35:   c = 7'h48;
            7'd36:   c = 7'h4A;
            7'd37:   c = 7'h4B;
            7'd38:   c = 7'h4C;
            7'd39:   c = 7'h2B;
            7'd40:   c = 7'h2A;
            7'd43:   c = 7'h7D;
            7'd44:   c = 7'h5A;
            7'd45:   c = 7'h58;
            7'd46:   c = 7'h43;
            7'd47:   c = 7'h56;
            7'd48:   c = 7'h42;
            7'd49:   c = 7'h4E;
            7'd50:   c = 7'h4D;
            7'd51:   c = 7'h3C;
            7'd52:   c = 7'h3E;
            7'd53:   c = 7'h3F;
            7'd55:   c = 7'h2A;
            7'd57:   c = 7'h20;
            7'h73:   c = 7'h5F; // ro key: underscore
            7'h7D:   c = 7'h7C; // yen key: bar
            default: c = CHAR_NONE;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/scd_ifs.sv */
// Handshake channels: raw scancode bytes in, decoded key events out.
`default_nettype none

interface scd_scan_if;
    logic       valid;
    logic       ready;
    logic [7:0] scan_byte;

    modport source (output valid, output scan_byte, input ready);
    modport sink   (input valid, input scan_byte, output ready);
endinterface

interface scd_key_if;
    logic       valid;
    logic       ready;
    logic       key_pressed;
    logic [7:0] key_code;
    logic [6:0] ascii_char;
    logic       char_valid;
    logic       interrupt_request;
    logic       shift_held;
    logic       ctrl_held;
    logic       alt_held;
    logic       caps_on;

    modport source (
        output valid, output key_pressed, output key_code, output ascii_char,
        output char_valid, output interrupt_request, output shift_held,
        output ctrl_held, output alt_held, output caps_on, input ready
    );
    modport sink (
        input valid, input key_pressed, input key_code, input ascii_char,
        input char_valid, input interrupt_request, input shift_held,
        input ctrl_held, input alt_held, input caps_on, output ready
    );
endinterface

`default_nettype wire

/* rtl/core/scd_translate.sv */
// Key code to character translation under the current modifier flags.
`default_nettype none

module scd_translate (
    input  logic [scd_pkg::CODE_W-1:0] code,
    input  logic                       ext,
    input  scd_pkg::mod_flags_t        flags,
    output logic [scd_pkg::CHAR_W-1:0] char_out
);
    import scd_pkg::*;

    logic [CHAR_W-1:0] base_char;
    logic [CHAR_W-1:0] caps_char;
    logic              is_lower;
    logic              is_upper;

    assign base_char = flags.shift ? shift_char(code) : plain_char(code);
    assign is_lower  = (base_char >= 7'h61) && (base_char <= 7'h7A);
    assign is_upper  = (base_char >= 7'h41) && (base_char <= 7'h5A);

    // caps flips case of letters; bit 5 is the case bit
    always_comb
    begin
        caps_char = base_char;
        if (flags.caps && ((!flags.shift && is_lower) || (flags.shift && is_upper)))
        begin
            caps_char = base_char ^ 7'h20;
        end
    end

    always_comb
    begin
        if (ext)
        begin
            unique case (code)
                EXT_KP_ENTER: char_out = CHAR_LF;
                EXT_KP_SLASH: char_out = 7'h2F;
                EXT_HOME:     char_out = CHAR_ESC;
                EXT_DELETE:   char_out = CHAR_DEL;
                default:      char_out = CHAR_NONE;
            endcase
        end
        else if (flags.ctrl && ((caps_char >= 7'h41 && caps_char <= 7'h5A) ||
                                (caps_char >= 7'h61 && caps_char <= 7'h7A)))
        begin
            // letters map to 1..26
            char_out = {2'b00, caps_char[4:0]};
        end
        else
        begin
            char_out = caps_char;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/scancode_set1_key_decoder.sv */
// Top level of the set-1 scancode key decoder.
// Decodes raw set-1 keyboard bytes (JIS layout) into key events. Each byte
// is taken into an input register, decoded by one combinational pass
// (modifier update, table lookup, caps and ctrl mapping) and the event is
// held in an output register until the consumer takes it. The block takes
// one byte per cycle; only a stalled consumer slows it. Each event
// is written to the output register as its byte leaves the input register,
// and the output register lets a new byte enter while the previous event
// still waits. A 0xE0 byte only arms the extended prefix and yields no
// event. Modifier flags (shift, ctrl, alt, caps lock) are updated before
// translation and reported with every event. Break codes still carry the
// translated character but never set char_valid or interrupt_request; a
// pressed key that maps to code 3 (ctrl-C) raises interrupt_request instead
// of char_valid.
`default_nettype none

module scancode_set1_key_decoder (
    input  logic              clk,
    input  logic              rst_n,
    scd_scan_if.sink          scan,
    scd_key_if.source         key
);
    import scd_pkg::*;

    // input stage
    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;

    // decoder state
    logic              prefix_reg;
    logic              prefix_next;
    mod_flags_t        flags_reg;
    mod_flags_t        flags_next;

    // output stage
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              pressed_reg;
    logic [7:0]        code_reg;
    logic [CHAR_W-1:0] char_reg;
    logic              char_valid_reg;
    logic              intr_reg;
    mod_flags_t        out_flags_reg;

    logic              s1_prefix;
    logic              s1_advance;
    logic              s1_emit;
    logic [CODE_W-1:0] s1_code;
    logic              s1_pressed;
    logic [CHAR_W-1:0] s1_char;

    assign s1_prefix  = (in_byte_reg == PREFIX_BYTE);
    assign s1_code    = in_byte_reg[CODE_W-1:0];
    assign s1_pressed = ~in_byte_reg[7];

    // a prefix byte leaves without needing the output register
    assign s1_advance = in_valid_reg && (s1_prefix || !out_valid_reg || key.ready);
    assign s1_emit    = s1_advance && !s1_prefix;
    assign scan.ready = !in_valid_reg || s1_advance;

    // modifier update, done before translation
    always_comb
    begin
        flags_next = flags_reg;
        if (!prefix_reg && (s1_code == KEY_LSHIFT || s1_code == KEY_RSHIFT))
        begin
            flags_next.shift = s1_pressed;
        end
        if (s1_code == KEY_CTRL)
        begin
            flags_next.ctrl = s1_pressed;
        end
        if (s1_code == KEY_ALT)
        begin
            flags_next.alt = s1_pressed;
        end
        if (!prefix_reg && s1_code == KEY_CAPS && s1_pressed)
        begin
            flags_next.caps = ~flags_reg.caps;
        end
    end

    scd_translate u_translate (
        .code     (s1_code),
        .ext      (prefix_reg),
        .flags    (flags_next),
        .char_out (s1_char)
    );

    always_comb
    begin
        prefix_next = prefix_reg;
        if (s1_advance)
        begin
            prefix_next = s1_prefix;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (key.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            prefix_reg    <= 1'b0;
            flags_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (scan.ready)
            begin
                in_valid_reg <= scan.valid;
            end
            prefix_reg    <= prefix_next;
            out_valid_reg <= out_valid_next;
            if (s1_emit)
            begin
                flags_reg <= flags_next;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (scan.ready && scan.valid)
        begin
            in_byte_reg <= scan.scan_byte;
        end
        if (s1_emit)
        begin
            pressed_reg    <= s1_pressed;
            code_reg       <= {prefix_reg, s1_code};
            char_reg       <= s1_char;
            char_valid_reg <= s1_pressed && (s1_char != CHAR_NONE) && (s1_char != CHAR_INTR);
            intr_reg       <= s1_pressed && (s1_char == CHAR_INTR);
            out_flags_reg  <= flags_next;
        end
    end

    assign key.valid             = out_valid_reg;
    assign key.key_pressed       = pressed_reg;
    assign key.key_code          = code_reg;
    assign key.ascii_char        = char_reg;
    assign key.char_valid        = char_valid_reg;
    assign key.interrupt_request = intr_reg;
    assign key.shift_held        = out_flags_reg.shift;
    assign key.ctrl_held         = out_flags_reg.ctrl;
    assign key.alt_held          = out_flags_reg.alt;
    assign key.caps_on           = out_flags_reg.caps;

endmodule

`default_nettype wire

/* tb/sv/tb_scancode_set1_key_decoder.sv */
// Self-checking testbench for the set-1 scancode key decoder.
`default_nettype none

module tb_scancode_set1_key_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    import scd_pkg::*;

    // Break bit of a raw byte, and a few characters the tables need.
    localparam logic [7:0] BREAK_BIT  = 8'h80;
    localparam logic [6:0] CHAR_BS    = 7'h08;
    localparam logic [6:0] CHAR_TAB   = 7'h09;
    localparam logic [6:0] CHAR_SLASH = 7'h2F;
    localparam logic [6:0] LOW_A      = 7'h61;
    localparam logic [6:0] LOW_Z      = 7'h7A;
    localparam logic [6:0] UP_A       = 7'h41;
    localparam logic [6:0] UP_Z       = 7'h5A;
    localparam int unsigned RANDOM_BYTES = 1650;

    // One decoded key event, as it should leave the block.
    typedef struct packed {
        logic       key_pressed;
        logic [7:0] key_code;
        logic [6:0] ascii_char;
        logic       char_valid;
        logic       interrupt_request;
        logic       shift_held;
        logic       ctrl_held;
        logic       alt_held;
        logic       caps_on;
    } key_event_t;

    // A byte to send, or a marker that makes the sender wait for the
    // decoder to drain completely before going on.
    typedef struct packed {
        logic [7:0] data;
        bit         drain;
    } scan_item_t;

    logic clk;
    logic rst_n;

    scd_scan_if scan_ch ();
    scd_key_if  key_ch ();

    scancode_set1_key_decoder u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .scan  (scan_ch),
        .key   (key_ch)
    );

    // Keyboard-side state of the predictor.
    logic       ext_armed;
    mod_flags_t held;
    logic [6:0] plain_tbl [128];
    logic [6:0] shift_tbl [128];

    scan_item_t  scan_backlog [$];
    key_event_t  key_events_due [$];
    key_event_t  want_ev;
    key_event_t  next_ev;

    int unsigned bytes_queued;
    int unsigned bytes_taken;
    int unsigned mismatch_count;

    // Transfer seen at the last rising edge, for the falling-edge drivers.
    logic scan_fired;
    logic key_fired;

    int unsigned send_hold;
    int unsigned take_hold;
    bit          send_calm;
    bit          take_calm;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // Key tables: fill a run of consecutive codes from a string.
    // ------------------------------------------------------------------
    function automatic void load_row(input bit shifted, input int first, input string s);
        for (int i = 0; i < s.len(); i++) begin
            if (shifted)
                shift_tbl[first + i] = 7'(s[i]);
            else
                plain_tbl[first + i] = 7'(s[i]);
        end
    endfunction

    // ------------------------------------------------------------------
    // Predictor: consumes one raw byte, updates the keyboard state and
    // returns 1 with the event when the byte produces one. A prefix byte
    // only arms the extended flag.
    // ------------------------------------------------------------------
    function automatic bit decode_keystroke(input logic [7:0] raw, output key_event_t ev);
        logic       ext;
        logic       pressed;
        logic [6:0] code;
        logic [6:0] c;
        ev = '0;
        if (raw == PREFIX_BYTE) begin
            ext_armed = 1'b1;
            return 1'b0;
        end
        ext       = ext_armed;
        ext_armed = 1'b0;
        pressed   = ~raw[7];
        code      = raw[6:0];

        // Modifiers update first, so the key itself sees the new state.
        if (!ext && (code == KEY_LSHIFT || code == KEY_RSHIFT))
            held.shift = pressed;
        if (code == KEY_CTRL)
            held.ctrl = pressed;
        if (code == KEY_ALT)
            held.alt = pressed;
        if (!ext && code == KEY_CAPS && pressed)
            held.caps = ~held.caps;

        if (ext) begin
            // Extended keys ignore shift, caps and ctrl.
            case (code)
                EXT_KP_ENTER: c = CHAR_LF;
                EXT_KP_SLASH: c = CHAR_SLASH;
                EXT_HOME:     c = CHAR_ESC;
                EXT_DELETE:   c = CHAR_DEL;
                default:      c = CHAR_NONE;
            endcase
        end else begin
            c = held.shift ? shift_tbl[code] : plain_tbl[code];
            // Caps inverts the case of letters only.
            if (held.caps && !held.shift && c >= LOW_A && c <= LOW_Z)
                c = c - LOW_A + UP_A;
            else if (held.caps && held.shift && c >= UP_A && c <= UP_Z)
                c = c - UP_A + LOW_A;
            if (held.ctrl) begin
                if (c >= LOW_A && c <= LOW_Z)
                    c = c - LOW_A + 7'd1;
                else if (c >= UP_A && c <= UP_Z)
                    c = c - UP_A + 7'd1;
            end
        end

        ev.key_pressed       = pressed;
        ev.key_code          = {ext, code};
        ev.ascii_char        = c;
        ev.char_valid        = pressed && c != CHAR_NONE && c != CHAR_INTR;
        ev.interrupt_request = pressed && c == CHAR_INTR;
        ev.shift_held        = held.shift;
        ev.ctrl_held         = held.ctrl;
        ev.alt_held          = held.alt;
        ev.caps_on           = held.caps;
        return 1'b1;
    endfunction

    function automatic void check_field(input string field, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0h actual %0h", $realtime, field, want, got);
            mismatch_count++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    function automatic void queue_byte(input logic [7:0] b);
        scan_item_t it;
        it.data  = b;
        it.drain = 1'b0;
        scan_backlog.push_back(it);
        bytes_queued++;
    endfunction

    function automatic void queue_drain();
        scan_item_t it;
        it.data  = 8'h00;
        it.drain = 1'b1;
        scan_backlog.push_back(it);
    endfunction

    // Mostly mapped keys, some JIS extras, some anything.
    function automatic logic [6:0] pick_code();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return 7'($urandom_range(1, 58));
        else if (r == 7)
            return $urandom_range(0, 1) ? 7'h73 : 7'h7D;
        else
            return 7'($urandom_range(0, 127));
    endfunction

    function automatic logic [6:0] pick_modifier();
        case ($urandom_range(0, 4))
            0:       return KEY_LSHIFT;
            1:       return KEY_RSHIFT;
            2:       return KEY_CTRL;
            3:       return KEY_ALT;
            default: return KEY_CAPS;
        endcase
    endfunction

    function automatic logic [6:0] pick_ext_code();
        case ($urandom_range(0, 5))
            0:       return EXT_KP_ENTER;
            1:       return EXT_KP_SLASH;
            2:       return EXT_HOME;
            3:       return EXT_DELETE;
            default: return 7'($urandom_range(0, 127));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Sender: presents the backlog at the falling edge. After each
    // transfer it idles for a drawn number of cycles; calm phases do not idle.
    // A drain marker holds valid low until no event is outstanding.
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        if (rst_n) begin
            if (!scan_ch.valid || scan_fired) begin
                if (send_hold != 0) begin
                    scan_ch.valid <= 1'b0;
                    send_hold--;
                end else if (scan_backlog.size() != 0 && scan_backlog[0].drain) begin
                    scan_ch.valid <= 1'b0;
                    if (key_events_due.size() == 0)
                        void'(scan_backlog.pop_front());
                end else if (scan_backlog.size() != 0) begin
                    scan_ch.valid     <= 1'b1;
                    scan_ch.scan_byte <= scan_backlog[0].data;
                    void'(scan_backlog.pop_front());
                    if ($urandom_range(0, 39) == 0)
                        send_calm = ~send_calm;
                    send_hold = send_calm ? 0 : $urandom_range(0, 18);
                end else begin
                    scan_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: after each transfer, draws a stall before taking the next
    // event. Calm phases keep ready high.
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        if (rst_n) begin
            if (key_fired || !key_ch.ready) begin
                if (key_fired) begin
                    if ($urandom_range(0, 39) == 0)
                        take_calm = ~take_calm;
                    take_hold = take_calm ? 0 : $urandom_range(0, 18);
                end
                if (take_hold != 0) begin
                    key_ch.ready <= 1'b0;
                    take_hold--;
                end else begin
                    key_ch.ready <= 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: at the rising edge, check an outgoing event against the
    // oldest prediction, then predict from an incoming byte. The two
    // never refer to the same transfer, since the decoder has latency.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            scan_fired <= 1'b0;
            key_fired  <= 1'b0;
        end else begin
            scan_fired <= scan_ch.valid && scan_ch.ready;
            key_fired  <= key_ch.valid && key_ch.ready;

            if (key_ch.valid && key_ch.ready) begin
                if (key_events_due.size() == 0) begin
                    $display("%0t: unexpected event expected none actual code %0h",
                             $realtime, key_ch.key_code);
                    mismatch_count++;
                end else begin
                    want_ev = key_events_due.pop_front();
                    check_field("key_pressed", want_ev.key_pressed, key_ch.key_pressed);
                    check_field("key_code", want_ev.key_code, key_ch.key_code);
                    check_field("ascii_char", want_ev.ascii_char, key_ch.ascii_char);
                    check_field("char_valid", want_ev.char_valid, key_ch.char_valid);
                    check_field("interrupt_request", want_ev.interrupt_request,
                                key_ch.interrupt_request);
                    check_field("shift_held", want_ev.shift_held, key_ch.shift_held);
                    check_field("ctrl_held", want_ev.ctrl_held, key_ch.ctrl_held);
                    check_field("alt_held", want_ev.alt_held, key_ch.alt_held);
                    check_field("caps_on", want_ev.caps_on, key_ch.caps_on);
                end
            end

            if (scan_ch.valid && scan_ch.ready) begin
                bytes_taken++;
                if (decode_keystroke(scan_ch.scan_byte, next_ev))
                    key_events_due.push_back(next_ev);
            end
        end
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #1000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence: tables, reset, stimulus, drain, verdict.
    // ------------------------------------------------------------------
    initial begin
        logic [6:0]  k;
        logic [6:0]  k2;
        logic [6:0]  m;
        int unsigned pick;

        rst_n             = 1'b0;
        scan_ch.valid     = 1'b0;
        scan_ch.scan_byte = 8'h00;
        key_ch.ready      = 1'b0;
        scan_fired        = 1'b0;
        key_fired         = 1'b0;
        send_hold         = 0;
        take_hold         = 0;
        send_calm         = 1'b0;
        take_calm         = 1'b0;
        bytes_queued      = 0;
        bytes_taken       = 0;
        mismatch_count    = 0;
        ext_armed         = 1'b0;
        held              = '0;

        // JIS tables, unmapped codes give no character.
        for (int i = 0; i < 128; i++) begin
            plain_tbl[i] = CHAR_NONE;
            shift_tbl[i] = CHAR_NONE;
        end
        plain_tbl[1]  = CHAR_ESC;  shift_tbl[1]  = CHAR_ESC;
        plain_tbl[14] = CHAR_BS;   shift_tbl[14] = CHAR_BS;
        plain_tbl[15] = CHAR_TAB;  shift_tbl[15] = CHAR_TAB;
        plain_tbl[28] = CHAR_LF;   shift_tbl[28] = CHAR_LF;
        load_row(1'b0, 2, "1234567890-^");
        load_row(1'b0, 16, "qwertyuiop@[");
        load_row(1'b0, 30, "asdfghjkl;:");
        load_row(1'b0, 43, "]zxcvbnm,./");
        load_row(1'b0, 55, "*");
        load_row(1'b0, 57, " ");
        load_row(1'b0, 'h73, "\\");
        load_row(1'b0, 'h7D, "\\");
        load_row(1'b1, 2, "!\"#$%&'()~=~");
        load_row(1'b1, 16, "QWERTYUIOP`{");
        load_row(1'b1, 30, "ASDFGHJKL+*");
        load_row(1'b1, 43, "}ZXCVBNM<>?");
        load_row(1'b1, 55, "*");
        load_row(1'b1, 57, " ");
        load_row(1'b1, 'h73, "_");
        load_row(1'b1, 'h7D, "|");

        // Directed part: byte extremes, caps and shift interplay, JIS keys,
        // ctrl-C, a break that still carries a character, repeated prefix,
        // each extended key with a character, a foreign prefix.
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_byte(8'h1E);                          // a
        queue_byte({1'b0, KEY_CAPS});               // caps on
        queue_byte(8'h1E);                          // A under caps
        queue_byte({1'b0, KEY_LSHIFT});
        queue_byte(8'h1E);                          // caps and shift: lower again
        queue_byte(8'h73);                          // ro key shifted
        queue_byte(8'h7D);                          // yen key shifted
        queue_byte({1'b1, KEY_LSHIFT});
        queue_byte({1'b1, KEY_CAPS});               // caps break, no toggle
        queue_byte({1'b0, KEY_CTRL});
        queue_byte(8'h2E);                          // ctrl-C
        queue_byte(8'hAE);                          // its break
        queue_byte({1'b1, KEY_CTRL});
        queue_byte(PREFIX_BYTE);
        queue_byte(PREFIX_BYTE);                    // prefix stays armed
        queue_byte({1'b0, EXT_KP_ENTER});
        queue_byte(PREFIX_BYTE);
        queue_byte({1'b0, EXT_KP_SLASH});
        queue_byte(PREFIX_BYTE);
        queue_byte({1'b0, EXT_HOME});
        queue_byte(PREFIX_BYTE);
        queue_byte(BREAK_BIT | {1'b0, EXT_DELETE});
        queue_byte(8'hE1);                          // not a prefix here
        queue_drain();

        // Random part: mostly plausible typing, some noise.
        while (bytes_queued < RANDOM_BYTES + 25) begin
            pick = $urandom_range(0, 19);
            if (pick <= 7) begin
                k = pick_code();
                queue_byte({1'b0, k});
                if ($urandom_range(0, 3) == 0) begin
                    // rollover: a second key pressed before the first is released
                    k2 = pick_code();
                    queue_byte({1'b0, k2});
                    queue_byte({1'b1, k2});
                end
                queue_byte({1'b1, k});
            end else if (pick <= 9) begin
                m = pick_modifier();
                if ($urandom_range(0, 3) == 0)
                    queue_byte(PREFIX_BYTE);
                queue_byte({1'($urandom_range(0, 1)), m});
            end else if (pick <= 11) begin
                // ctrl chord, which reaches ctrl-C now and then
                queue_byte({1'b0, KEY_CTRL});
                k = ($urandom_range(0, 2) == 0) ? 7'h2E : pick_code();
                queue_byte({1'b0, k});
                queue_byte({1'b1, k});
                queue_byte({1'b1, KEY_CTRL});
            end else if (pick <= 13) begin
                m = $urandom_range(0, 1) ? KEY_LSHIFT : KEY_RSHIFT;
                queue_byte({1'b0, m});
                k = pick_code();
                queue_byte({1'b0, k});
                queue_byte({1'b1, k});
                queue_byte({1'b1, m});
            end else if (pick <= 15) begin
                queue_byte(PREFIX_BYTE);
                queue_byte({1'($urandom_range(0, 1)), pick_ext_code()});
            end else if (pick == 16) begin
                queue_byte(PREFIX_BYTE);
                queue_byte(PREFIX_BYTE);
                queue_byte(8'($urandom_range(0, 255)));
            end else if (pick <= 18) begin
                queue_byte(8'($urandom_range(0, 255)));
            end else begin
                if ($urandom_range(0, 7) == 0)
                    queue_drain();
                else
                    queue_byte(8'($urandom_range(0, 255)));
            end
        end

        // Hold reset, then release it on a falling edge.
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Everything sent, everything received, then idle cycles to catch a stray event.
        while (bytes_taken != bytes_queued)
            @(negedge clk);
        while (key_events_due.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
